[sv/psq_pkg.sv]
// Shared types and constants for the positional sequence store.
// Command and status codes, field widths, controller/datapath handshake structs.
// No dependencies.
package psq_pkg;

  localparam int CMD_W    = 4;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = 3;

  // Register index, taken from paddr[ADDR_W-1]
  localparam logic REG_EMPTY_VALUE = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR        = 4'd0,
    CMD_READ         = 4'd1,
    CMD_WRITE        = 4'd2,
    CMD_INSERT_AT    = 4'd3,
    CMD_INSERT_FRONT = 4'd4,
    CMD_INSERT_REAR  = 4'd5,
    CMD_DELETE_AT    = 4'd6,
    CMD_DELETE_MATCH = 4'd7,
    CMD_SIZE         = 4'd8
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture the input transfer
    logic init;      // decode command, check position, set up the sweep
    logic issue_rd;  // read one entry and step the read pointer
    logic finish;    // apply the final write and count update
    logic emit;      // load the result register
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic reads_left;
    logic pend;
    logic out_busy;
  } stat_t;

endpackage

[sv/psq_cmd_if.sv]
// Command channel: valid/ready handshake carrying one command item.
// Depends on psq_pkg for field widths.
interface psq_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [psq_pkg::CMD_W-1:0]         command;
  logic [psq_pkg::POS_W-1:0]         position;
  logic signed [psq_pkg::DATA_W-1:0] value;

  modport source (output valid, command, position, value, input ready);
  modport sink   (input valid, command, position, value, output ready);
endinterface

[sv/psq_res_if.sv]
// Result channel: valid/ready handshake carrying one result item.
// Depends on psq_pkg for field widths.
interface psq_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [psq_pkg::DATA_W-1:0]   read_value;
  logic [psq_pkg::COUNT_W-1:0]         entry_count;
  logic                                is_empty;
  logic [psq_pkg::STATUS_W-1:0]        status;

  modport source (output valid, read_value, entry_count, is_empty, status, input ready);
  modport sink   (input valid, read_value, entry_count, is_empty, status, output ready);
endinterface

[sv/psq_ctrl.sv]
// Sequencer for the positional sequence store: steps each command through
// decode, entry sweep, final update and result hand-off. Depends on psq_pkg.
module psq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  psq_pkg::stat_t  stat,
  output psq_pkg::ctl_t   ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_RUN,
    S_FINISH,
    S_RESULT
  } state_t;

  state_t state;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:   if (cmd_valid) state <= S_INIT;
        S_INIT:   state <= S_RUN;
        S_RUN:    if (!stat.reads_left && !stat.pend) state <= S_FINISH;
        S_FINISH: state <= S_RESULT;
        S_RESULT: if (!stat.out_busy) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // Command decode per state
  always_comb begin
    ctl       = '0;
    cmd_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        ctl.load  = cmd_valid;
      end
      S_INIT:   ctl.init     = 1'b1;
      S_RUN:    ctl.issue_rd = stat.reads_left;
      S_FINISH: ctl.finish   = 1'b1;
      S_RESULT: ctl.emit     = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

[sv/psq_dp.sv]
// Datapath of the positional sequence store: entry memory, sweep pointers,
// live count and result register. Driven by psq_ctrl; depends on psq_pkg.
module psq_dp #(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  psq_pkg::ctl_t                       ctl,
  output psq_pkg::stat_t                      stat,
  input  logic [psq_pkg::CMD_W-1:0]           command,
  input  logic [psq_pkg::POS_W-1:0]           position,
  input  logic signed [psq_pkg::DATA_W-1:0]   value,
  input  logic signed [psq_pkg::DATA_W-1:0]   empty_value,
  input  logic                                res_ready,
  output logic                                res_valid,
  output logic signed [psq_pkg::DATA_W-1:0]   read_value,
  output logic [psq_pkg::COUNT_W-1:0]         entry_count,
  output logic                                is_empty,
  output logic [psq_pkg::STATUS_W-1:0]        status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > psq_pkg::POS_W) ? CW : psq_pkg::POS_W;
  localparam int VW = (ELEM_WIDTH < psq_pkg::DATA_W) ? ELEM_WIDTH : psq_pkg::DATA_W;

  typedef enum logic [2:0] {
    M_NONE,
    M_READ,
    M_WRITE,
    M_INSERT,
    M_DEL_AT,
    M_DEL_MATCH,
    M_CLEAR
  } mode_t;

  logic [ELEM_WIDTH-1:0] mem [DEPTH];

  logic [psq_pkg::CMD_W-1:0]         cmd_q;
  logic [XW-1:0]                     pos_q;
  logic [ELEM_WIDTH-1:0]             val_q;
  logic [CW-1:0]                     count;
  logic [CW-1:0]                     rd_idx, wr_idx, rd_left;
  logic                              rd_dn;
  logic                              pend;
  logic [ELEM_WIDTH-1:0]             rd_data;
  mode_t                             mode;
  psq_pkg::status_t                  res_status;
  logic signed [psq_pkg::DATA_W-1:0] res_value;

  // Decode results used at init
  logic                              pos_lt, pos_le, full, ins_ok;
  logic [CW-1:0]                     pos_c, ins_pos;
  mode_t                             i_mode;
  psq_pkg::status_t                  i_status;
  logic [CW-1:0]                     i_rd_idx, i_wr_idx, i_rd_left;
  logic                              i_dn;
  logic signed [psq_pkg::DATA_W-1:0] i_value;
  logic [XW-1:0]                     i_pos;

  // Memory write port
  logic                              mem_we;
  logic [AW-1:0]                     waddr;
  logic [ELEM_WIDTH-1:0]             wdata;

  assign stat.reads_left = (rd_left != '0);
  assign stat.pend       = pend;
  assign stat.out_busy   = res_valid && !res_ready;

  // Position checks and insert target
  always_comb begin
    pos_lt  = pos_q < XW'(count);
    pos_le  = pos_q <= XW'(count);
    full    = (count == CW'(DEPTH));
    pos_c   = pos_q[CW-1:0];
    ins_pos = (cmd_q == psq_pkg::CMD_INSERT_FRONT) ? '0 :
              (cmd_q == psq_pkg::CMD_INSERT_REAR)  ? count : pos_c;
    ins_ok  = (cmd_q != psq_pkg::CMD_INSERT_AT) || pos_le;
  end

  // Command decode: mode, status and sweep setup
  always_comb begin
    i_mode    = M_NONE;
    i_status  = psq_pkg::ST_DONE;
    i_rd_idx  = '0;
    i_wr_idx  = '0;
    i_rd_left = '0;
    i_dn      = 1'b0;
    i_value   = '0;
    i_pos     = pos_q;
    unique case (cmd_q)
      psq_pkg::CMD_CLEAR: i_mode = M_CLEAR;
      psq_pkg::CMD_READ: begin
        if (pos_lt) begin
          i_mode    = M_READ;
          i_rd_idx  = pos_c;
          i_rd_left = CW'(1);
        end else begin
          i_status = psq_pkg::ST_BAD_POS;
          i_value  = empty_value;
        end
      end
      psq_pkg::CMD_WRITE: begin
        if (pos_lt) i_mode = M_WRITE;
        else        i_status = psq_pkg::ST_BAD_POS;
      end
      psq_pkg::CMD_INSERT_AT, psq_pkg::CMD_INSERT_FRONT, psq_pkg::CMD_INSERT_REAR: begin
        if (!ins_ok) begin
          i_status = psq_pkg::ST_BAD_POS;
        end else if (full) begin
          i_status = psq_pkg::ST_FULL;
        end else begin
          // move entries from the tail down to the insert point up one place
          i_mode    = M_INSERT;
          i_pos     = XW'(ins_pos);
          i_rd_idx  = count - CW'(1);
          i_wr_idx  = count;
          i_rd_left = count - ins_pos;
          i_dn      = 1'b1;
        end
      end
      psq_pkg::CMD_DELETE_AT: begin
        if (pos_lt) begin
          i_mode    = M_DEL_AT;
          i_rd_idx  = pos_c + CW'(1);
          i_wr_idx  = pos_c;
          i_rd_left = count - pos_c - CW'(1);
        end else begin
          i_status = psq_pkg::ST_BAD_POS;
        end
      end
      psq_pkg::CMD_DELETE_MATCH: begin
        // compact the whole sequence, dropping matches
        i_mode    = M_DEL_MATCH;
        i_rd_left = count;
      end
      psq_pkg::CMD_SIZE: ;
      default: i_status = psq_pkg::ST_BAD_POS;
    endcase
  end

  // Write port select: sweep writes, then the final write
  always_comb begin
    mem_we = 1'b0;
    waddr  = wr_idx[AW-1:0];
    wdata  = rd_data;
    if (pend) begin
      unique case (mode)
        M_INSERT, M_DEL_AT: mem_we = 1'b1;
        M_DEL_MATCH:        mem_we = (rd_data != val_q);
        default: ;
      endcase
    end
    if (ctl.finish && (mode == M_INSERT || mode == M_WRITE)) begin
      mem_we = 1'b1;
      waddr  = pos_q[AW-1:0];
      wdata  = val_q;
    end
  end

  // Entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (ctl.issue_rd) rd_data <= mem[rd_idx[AW-1:0]];
  end

  // Control state: count, sweep progress, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_left   <= '0;
      pend      <= 1'b0;
      mode      <= M_NONE;
      res_valid <= 1'b0;
    end else begin
      pend <= ctl.issue_rd;
      if (ctl.init) begin
        mode    <= i_mode;
        rd_left <= i_rd_left;
      end else if (ctl.issue_rd) begin
        rd_left <= rd_left - CW'(1);
      end
      if (ctl.finish) begin
        unique case (mode)
          M_CLEAR:     count <= '0;
          M_INSERT:    count <= count + CW'(1);
          M_DEL_AT:    count <= count - CW'(1);
          M_DEL_MATCH: count <= wr_idx;
          default: ;
        endcase
      end
      if (ctl.emit) res_valid <= 1'b1;
      else if (res_valid && res_ready) res_valid <= 1'b0;
    end
  end

  // Payload: captured item, pointers, result fields
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= command;
      pos_q <= XW'(position);
      val_q <= ELEM_WIDTH'(value[VW-1:0]);
    end
    if (ctl.init) begin
      pos_q      <= i_pos;
      rd_idx     <= i_rd_idx;
      wr_idx     <= i_wr_idx;
      rd_dn      <= i_dn;
      res_status <= i_status;
      res_value  <= i_value;
    end
    if (ctl.issue_rd) rd_idx <= rd_dn ? rd_idx - CW'(1) : rd_idx + CW'(1);
    if (pend) begin
      unique case (mode)
        M_INSERT:    wr_idx <= wr_idx - CW'(1);
        M_DEL_AT:    wr_idx <= wr_idx + CW'(1);
        M_DEL_MATCH: if (rd_data != val_q) wr_idx <= wr_idx + CW'(1);
        M_READ:      res_value <= psq_pkg::DATA_W'($signed(rd_data));
        default: ;
      endcase
    end
    if (ctl.emit) begin
      read_value  <= res_value;
      entry_count <= psq_pkg::COUNT_W'(count);
      is_empty    <= (count == '0);
      status      <= res_status;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("live count exceeds depth");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> !(res_valid && !res_ready))
    else $error("result loaded over a pending result");

  a_no_collide: assert property (@(posedge clk) disable iff (rst)
    ctl.issue_rd |-> (rd_left != '0) && !(mem_we && waddr == rd_idx[AW-1:0]))
    else $error("sweep read past its range or onto the written entry");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !ctl.finish |=> $stable(count))
    else $error("live count changed outside the final update");
`endif

endmodule

[sv/positional_sequence_store_core.sv]
// Each command passes through decode, the entry sweep, the final update and the
// result hand-off; the sweep reads k entries (read: 1, insert/delete: entries
// moved, delete matching: live count), one memory read per cycle.
// One command at a time: a new transfer is taken in the cycle after the result
// is loaded.
// Reset clears count, sequencer and result valid; entry memory is not cleared.
module positional_sequence_store_core #(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  psq_cmd_if.sink                       cmd,
  psq_res_if.source                     res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psq_pkg::ADDR_W-1:0]    paddr,
  input  logic [psq_pkg::DATA_W-1:0]    pwdata,
  output logic [psq_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  logic signed [psq_pkg::DATA_W-1:0] empty_value;
  psq_pkg::ctl_t                     ctl;
  psq_pkg::stat_t                    stat;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_value <= '0;
    end else if (psel && penable && pwrite &&
                 paddr[psq_pkg::ADDR_W-1] == psq_pkg::REG_EMPTY_VALUE) begin
      empty_value <= pwdata;
    end
  end

  assign prdata = (paddr[psq_pkg::ADDR_W-1] == psq_pkg::REG_EMPTY_VALUE) ? empty_value : '0;

  psq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  psq_dp #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .command     (cmd.command),
    .position    (cmd.position),
    .value       (cmd.value),
    .empty_value (empty_value),
    .res_ready   (res.ready),
    .res_valid   (res.valid),
    .read_value  (res.read_value),
    .entry_count (res.entry_count),
    .is_empty    (res.is_empty),
    .status      (res.status)
  );

endmodule
